@@ rtl/rmt_pkg.sv @@
package rmt_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int MEDIAN_WIDTH = SAMPLE_WIDTH + 1;
	localparam int COUNT_WIDTH = 11;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [MEDIAN_WIDTH-1:0] median_t;

	typedef struct packed {
		sample_t sample_value;
		logic    clear_store;
	} sample_item_t;

	typedef struct packed {
		median_t                median_doubled;
		logic [COUNT_WIDTH-1:0] sample_count;
		logic                   sample_dropped;
	} result_item_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP_INSERT,
		OP_PUSH
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		sample_t  key;
		sample_t  push;
	} chain_ctrl_t;

endpackage

@@ rtl/running_median_tracker_unit.sv @@
// Channel  Handshake                     Payload
// sample   sample_valid / sample_stall   sample (sample_value, clear_store)
// result   result_valid / result_stall   result (median_doubled, sample_count, sample_dropped)
//
// One item per cycle unless stalled; its result is registered in the cycle after acceptance.
// The rate is set by the two chains of cells, which place a sample in all cells at once.
// Reset clears the counts and the output register's valid flag; no clearing pass is needed.
// A waiting result stalls the sample side only while result_stall is high.
module running_median_tracker_unit #(
	parameter int CAPACITY = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  rmt_pkg::sample_item_t sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output rmt_pkg::result_item_t result
);
	import rmt_pkg::*;

	localparam int LOWER_DEPTH = (CAPACITY + 1) / 2;
	localparam int UPPER_DEPTH = CAPACITY / 2;
	localparam int LOWER_CW = $clog2(LOWER_DEPTH + 1);
	localparam int UPPER_CW = $clog2(UPPER_DEPTH + 1);
	localparam int TOTAL_CW = $clog2(CAPACITY + 1);

	logic [LOWER_CW-1:0] lower_count_q;
	logic [UPPER_CW-1:0] upper_count_q;
	logic                result_valid_q;
	result_item_t        result_q;

	logic                accept;
	sample_t             x;
	logic [LOWER_CW-1:0] lower_cnt;
	logic [UPPER_CW-1:0] upper_cnt;
	logic [LOWER_CW-1:0] lower_cnt_n;
	logic [UPPER_CW-1:0] upper_cnt_n;
	logic [TOTAL_CW-1:0] total;
	logic [TOTAL_CW-1:0] total_n;
	logic                full;
	logic                balanced;
	logic                to_lower;
	logic                upper_valid;
	logic                lower_second_valid;
	sample_t             lower_head;
	sample_t             lower_second;
	sample_t             upper_head;
	sample_t             upper_second;
	sample_t             head_lo_n;
	sample_t             head_hi_n;
	logic                odd_n;
	median_t             head_lo_ext;
	median_t             head_hi_ext;
	chain_ctrl_t         lower_ctrl;
	chain_ctrl_t         upper_ctrl;
	result_item_t        result_d;

	assign accept = sample_valid && !sample_stall;
	assign x = sample.sample_value;
	assign lower_cnt = sample.clear_store ? '0 : lower_count_q;
	assign upper_cnt = sample.clear_store ? '0 : upper_count_q;
	assign total = TOTAL_CW'(lower_cnt) + TOTAL_CW'(upper_cnt);
	assign full = (total >= TOTAL_CW'(CAPACITY));
	assign balanced = (TOTAL_CW'(lower_cnt) == TOTAL_CW'(upper_cnt));
	assign upper_valid = (upper_cnt != '0);
	assign lower_second_valid = (lower_cnt > LOWER_CW'(1));
	assign to_lower = (lower_cnt != '0) && (x < lower_head);

	rmt_chain #(
		.DEPTH(LOWER_DEPTH),
		.CNT_W(LOWER_CW),
		.DESCEND(1'b1)
	) u_lower (
		.clk(clk),
		.ctrl(lower_ctrl),
		.count(lower_cnt),
		.head(lower_head),
		.second(lower_second)
	);

	rmt_chain #(
		.DEPTH(UPPER_DEPTH),
		.CNT_W(UPPER_CW),
		.DESCEND(1'b0)
	) u_upper (
		.clk(clk),
		.ctrl(upper_ctrl),
		.count(upper_cnt),
		.head(upper_head),
		.second(upper_second)
	);

	always_comb begin
		lower_ctrl = '{op: OP_HOLD, key: x, push: x};
		upper_ctrl = '{op: OP_HOLD, key: x, push: x};
		lower_cnt_n = lower_cnt;
		upper_cnt_n = upper_cnt;
		head_lo_n = lower_head;
		head_hi_n = upper_head;
		odd_n = !balanced;
		total_n = total;
		priority if (full) begin
			head_lo_n = lower_head;
			head_hi_n = upper_head;
		end else if (to_lower && balanced) begin
			lower_ctrl.op = OP_INSERT;
			lower_cnt_n = lower_cnt + LOWER_CW'(1);
			odd_n = 1'b1;
		end else if (to_lower) begin
			// The lower maximum moves across to the head of the upper half.
			lower_ctrl.op = OP_POP_INSERT;
			upper_ctrl.op = OP_PUSH;
			upper_ctrl.push = lower_head;
			upper_cnt_n = upper_cnt + UPPER_CW'(1);
			head_lo_n = (lower_second_valid && (lower_second > x)) ? lower_second : x;
			head_hi_n = lower_head;
			odd_n = 1'b0;
		end else if (!balanced) begin
			upper_ctrl.op = OP_INSERT;
			upper_cnt_n = upper_cnt + UPPER_CW'(1);
			head_hi_n = (upper_valid && (upper_head < x)) ? upper_head : x;
			odd_n = 1'b0;
		end else if (!upper_valid || (x <= upper_head)) begin
			lower_ctrl.op = OP_PUSH;
			lower_ctrl.push = x;
			lower_cnt_n = lower_cnt + LOWER_CW'(1);
			head_lo_n = x;
			odd_n = 1'b1;
		end else begin
			// The upper minimum moves across to the lower half and the sample takes its place.
			lower_ctrl.op = OP_PUSH;
			lower_ctrl.push = upper_head;
			upper_ctrl.op = OP_POP_INSERT;
			lower_cnt_n = lower_cnt + LOWER_CW'(1);
			head_lo_n = upper_head;
			odd_n = 1'b1;
		end
		if (!full) begin
			total_n = total + TOTAL_CW'(1);
		end
		if (!accept) begin
			lower_ctrl.op = OP_HOLD;
			upper_ctrl.op = OP_HOLD;
		end
	end

	assign head_lo_ext = {head_lo_n[SAMPLE_WIDTH-1], head_lo_n};
	assign head_hi_ext = {head_hi_n[SAMPLE_WIDTH-1], head_hi_n};

	always_comb begin
		result_d.median_doubled = head_lo_ext + (odd_n ? head_lo_ext : head_hi_ext);
		result_d.sample_count = COUNT_WIDTH'(total_n);
		result_d.sample_dropped = full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_count_q <= '0;
			upper_count_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				lower_count_q <= lower_cnt_n;
				upper_count_q <= upper_cnt_n;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign sample_stall = result_valid_q && result_stall;
	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_halves_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		(TOTAL_CW'(lower_count_q) == TOTAL_CW'(upper_count_q)) ||
		(TOTAL_CW'(lower_count_q) == TOTAL_CW'(upper_count_q) + TOTAL_CW'(1)))
		else $error("lower and upper halves out of balance");

	a_capacity_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(TOTAL_CW'(lower_count_q) + TOTAL_CW'(upper_count_q)) <= TOTAL_CW'(CAPACITY))
		else $error("store holds more samples than its capacity");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sample.clear_store) |=> (result.sample_count == COUNT_WIDTH'(1)))
		else $error("clearing item did not leave exactly one sample");

	a_drop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full) |=> (result_valid && result.sample_dropped))
		else $error("full store did not flag the dropped sample");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid)
		else $error("sample side stalled with no result waiting");

	a_upper_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(upper_count_q > UPPER_CW'(1)) |-> (upper_head <= upper_second))
		else $error("upper half out of order at its head");
`endif

endmodule

@@ rtl/rmt_cell.sv @@
module rmt_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 1,
	parameter bit DESCEND = 1'b0
) (
	input  logic                 clk,
	input  rmt_pkg::chain_ctrl_t ctrl,
	input  logic [CNT_W-1:0]     count,
	input  rmt_pkg::sample_t     left_value,
	input  logic                 left_after,
	input  rmt_pkg::sample_t     right_value,
	input  logic                 right_after,
	output rmt_pkg::sample_t     value,
	output logic                 after
);
	import rmt_pkg::*;

	localparam bit FIRST = (INDEX == 0);

	sample_t value_q;
	sample_t value_d;
	logic    beyond;
	logic    past_key;

	// A cell is past the insertion point when it is empty or its value sorts after the key.
	assign beyond = (count <= CNT_W'(INDEX));
	assign past_key = DESCEND ? (value_q < ctrl.key) : (value_q > ctrl.key);
	assign after = beyond || past_key;
	assign value = value_q;

	always_comb begin
		value_d = value_q;
		unique case (ctrl.op)
			OP_HOLD: begin
				value_d = value_q;
			end
			OP_INSERT: begin
				if (!after) begin
					value_d = value_q;
				end else if (left_after) begin
					value_d = left_value;
				end else begin
					value_d = ctrl.key;
				end
			end
			OP_POP_INSERT: begin
				if (!right_after) begin
					value_d = right_value;
				end else if (!FIRST && after) begin
					value_d = value_q;
				end else begin
					value_d = ctrl.key;
				end
			end
			OP_PUSH: begin
				value_d = left_value;
			end
			default: begin
				value_d = value_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

@@ rtl/rmt_chain.sv @@
module rmt_chain #(
	parameter int DEPTH = 512,
	parameter int CNT_W = 10,
	parameter bit DESCEND = 1'b0
) (
	input  logic                 clk,
	input  rmt_pkg::chain_ctrl_t ctrl,
	input  logic [CNT_W-1:0]     count,
	output rmt_pkg::sample_t     head,
	output rmt_pkg::sample_t     second
);
	import rmt_pkg::*;

	sample_t          values [DEPTH];
	sample_t          left_v [DEPTH];
	sample_t          right_v [DEPTH];
	logic [DEPTH-1:0] afters;
	logic [DEPTH-1:0] left_a;
	logic [DEPTH-1:0] right_a;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_v[i] = ctrl.push;
			assign left_a[i] = 1'b0;
		end else begin : g_inner_left
			assign left_v[i] = values[i-1];
			assign left_a[i] = afters[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_v[i] = values[i];
			assign right_a[i] = 1'b1;
		end else begin : g_inner_right
			assign right_v[i] = values[i+1];
			assign right_a[i] = afters[i+1];
		end

		rmt_cell #(
			.INDEX(i),
			.CNT_W(CNT_W),
			.DESCEND(DESCEND)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.count(count),
			.left_value(left_v[i]),
			.left_after(left_a[i]),
			.right_value(right_v[i]),
			.right_after(right_a[i]),
			.value(values[i]),
			.after(afters[i])
		);
	end

	assign head = values[0];

	if (DEPTH > 1) begin : g_second
		assign second = values[1];
	end else begin : g_no_second
		assign second = values[0];
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import rmt_pkg::*;

	localparam int CAPACITY = 1024;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 10;

	logic         clk;
	logic         arst_n;
	logic         sample_valid;
	logic         sample_stall;
	sample_item_t sample;
	logic         result_valid;
	logic         result_stall;
	result_item_t result;

	int           held_samples[$];
	result_item_t pending_results[$];
	int           mismatch_count = 0;
	int           burst_left = 0;
	int           hold_request = 0;
	int           idle_cycles = 0;

	running_median_tracker_unit #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Keeps every held sample in one ascending list; the lower half is its first ceil(n/2)
	// entries, so the middle entries give the doubled median directly.
	function automatic result_item_t predict_median(input sample_item_t item);
		result_item_t r;
		int value;
		int pos;
		int n;
		int doubled;
		logic dropped;
		value = item.sample_value;
		dropped = 1'b0;
		if (item.clear_store) begin
			held_samples.delete();
		end
		if (held_samples.size() >= CAPACITY) begin
			dropped = 1'b1;
		end else begin
			pos = held_samples.size();
			while (pos > 0 && held_samples[pos - 1] > value) pos--;
			held_samples.insert(pos, value);
		end
		n = held_samples.size();
		if (n == 0) begin
			doubled = 0;
		end else if (n % 2 == 1) begin
			doubled = 2 * held_samples[n / 2];
		end else begin
			doubled = held_samples[n / 2 - 1] + held_samples[n / 2];
		end
		r.median_doubled = median_t'(doubled);
		r.sample_count = n[COUNT_WIDTH-1:0];
		r.sample_dropped = dropped;
		return r;
	endfunction

	function automatic int random_value();
		sample_t raw;
		raw = sample_t'($urandom);
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return -32768;
					1: return 32767;
					2: return 0;
					default: return -1;
				endcase
			end
			1, 2: return $urandom_range(0, 8) - 4;
			default: return raw;
		endcase
	endfunction

	task automatic send_sample(input int value, input bit clr);
		sample_item_t item;
		int gap;
		item.sample_value = sample_t'(value);
		item.clear_store = clr;
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= item;
		do @(posedge clk); while (sample_stall);
		pending_results.push_back(predict_median(item));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(0, 12);
		end
	endtask

	task automatic pause_sender();
		@(negedge clk);
		sample_valid <= 1'b0;
	endtask

	task automatic wait_for_results();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_extremes();
		send_sample(-32768, 1'b1);
		send_sample(32767, 1'b0);
		send_sample(0, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(1, 1'b0);
		send_sample(32767, 1'b0);
		send_sample(32767, 1'b0);
		send_sample(-32768, 1'b0);
		send_sample(-32768, 1'b0);
		send_sample(32767, 1'b1);
		send_sample(32767, 1'b0);
	endtask

	task automatic test_equal_values();
		send_sample(5, 1'b1);
		send_sample(5, 1'b0);
		send_sample(5, 1'b0);
		send_sample(4, 1'b0);
		send_sample(6, 1'b0);
		send_sample(5, 1'b0);
		send_sample(5, 1'b0);
	endtask

	task automatic test_clear_with_sample();
		send_sample(100, 1'b1);
		send_sample(200, 1'b0);
		send_sample(-300, 1'b1);
		send_sample(-300, 1'b1);
		send_sample(-21846, 1'b1);
		send_sample(21845, 1'b0);
	endtask

	task automatic test_full_store();
		send_sample(random_value(), 1'b1);
		repeat (CAPACITY - 1) send_sample(random_value(), 1'b0);
		repeat (20) send_sample(random_value(), 1'b0);
		send_sample(-32768, 1'b0);
		send_sample(32767, 1'b0);
		send_sample(random_value(), 1'b1);
	endtask

	task automatic test_long_hold_off();
		hold_request = 400;
		repeat (40) send_sample(random_value(), $urandom_range(0, 15) == 0);
	endtask

	task automatic test_sender_pause();
		pause_sender();
		wait_for_results();
		repeat (20) send_sample(random_value(), $urandom_range(0, 9) == 0);
	endtask

	task automatic test_random_stream();
		repeat (460) send_sample(random_value(), $urandom_range(0, 39) == 0);
	endtask

	initial begin
		int stall_mode;
		int mode_left;
		int hold_left;
		stall_mode = 0;
		mode_left = 0;
		hold_left = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 200);
				end
				mode_left--;
				case (stall_mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 3) == 0);
					default: result_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result: median %0d count %0d dropped %0b",
						result.median_doubled, result.sample_count, result.sample_dropped);
				end
			end else begin
				want = pending_results.pop_front();
				if (result.median_doubled !== want.median_doubled ||
						result.sample_count !== want.sample_count ||
						result.sample_dropped !== want.sample_dropped) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: expected median %0d count %0d dropped %0b, got median %0d count %0d dropped %0b",
							want.median_doubled, want.sample_count, want.sample_dropped,
							result.median_doubled, result.sample_count,
							result.sample_dropped);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_equal_values();
		test_clear_with_sample();
		test_full_store();
		test_long_hold_off();
		test_sender_pause();
		test_random_stream();

		pause_sender();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
